@@ hw/rtl/jtcu_pkg.sv @@
// Package: opcodes, stage payload types and helpers for the type conversion unit.
`timescale 1ns / 1ps
package jtcu_pkg;

  localparam int unsigned OpW   = 4;
  localparam int unsigned DataW = 64;

  typedef enum logic [3:0] {
    OP_I2L = 4'd0,  OP_I2F = 4'd1,  OP_I2D = 4'd2,  OP_L2I = 4'd3,
    OP_L2F = 4'd4,  OP_L2D = 4'd5,  OP_F2I = 4'd6,  OP_F2L = 4'd7,
    OP_F2D = 4'd8,  OP_D2I = 4'd9,  OP_D2L = 4'd10, OP_D2F = 4'd11,
    OP_I2B = 4'd12, OP_I2C = 4'd13, OP_I2S = 4'd14, OP_NONE = 4'd15
  } op_t;

  // Unpacked operand, produced by the decode stage.
  typedef struct packed {
    op_t         op;
    logic        neg;       // sign of the value
    logic [63:0] mag;       // integer magnitude, or significand (hidden bit at 63)
    logic [6:0]  lz;        // leading zero count of mag
    logic        is_zero;   // zero or (for fp) zero/subnormal flushed where relevant
    logic        is_nan;
    logic        is_inf;
    logic signed [12:0] uexp;  // unbiased exponent of mag bit 63 (fp ops)
    logic [63:0] raw;       // direct result for simple ops
  } dec_t;

  // Normalized value, produced by the shift stage.
  typedef struct packed {
    op_t         op;
    logic        neg;
    logic [63:0] norm;      // value left-justified, leading one at bit 63
    logic signed [12:0] uexp;
    logic        is_zero;
    logic        is_nan;
    logic        is_inf;
    logic [63:0] raw;
  } nrm_t;

  // Leading zero count over 64 bits.
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(63 - i);
    end
    return n;
  endfunction

  // Right shift with sticky, amount saturating.
  function automatic logic [63:0] shr_sticky(input logic [63:0] v, input logic [6:0] sh);
    logic [63:0] o;
    logic        st;
    if (sh >= 7'd64) begin
      o  = '0;
      st = |v;
    end else begin
      o  = v >> sh;
      st = |(v & ~(64'hFFFF_FFFF_FFFF_FFFF << sh));
    end
    return {o[63:1], o[0] | st};
  endfunction

endpackage

@@ hw/rtl/jvm_type_conversion_unit.sv @@
// Top level: three-stage pipelined JVM primitive conversion unit.
//
//   channel | ports                            | direction
//   in      | in_valid in_ready in_operation   | into block
//           | in_operand_bits                  |
//   out     | out_valid out_ready out_result_bits | out of block
//
// Stages: decode, normalize, round/pack. One item per cycle is sustained
// while out_ready is high, over a chain of valid-tagged registers.
// A stage advances when the stage after it is empty or moving, so a stall
// at the output holds every full stage and loses nothing.
// Synchronous reset clears the valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module jvm_type_conversion_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_operation,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_bits
);
  jtcu_pkg::dec_t dec_nxt, dec_r;
  jtcu_pkg::nrm_t nrm_nxt, nrm_r;
  logic [63:0]    res_nxt, res_r;
  logic           v1_r, v2_r, v3_r;
  logic           adv1, adv2, adv3;

  // Stage enables
  assign adv3 = !v3_r || out_ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_ready = adv1;

  jtcu_decode u_dec (.op_i(in_operation), .bits_i(in_operand_bits), .dec_o(dec_nxt));
  jtcu_normalize u_nrm (.dec_i(dec_r), .nrm_o(nrm_nxt));
  jtcu_pack u_pack (.nrm_i(nrm_r), .result_o(res_nxt));

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv1) dec_r <= dec_nxt;
    if (adv2) nrm_r <= nrm_nxt;
    if (adv3) res_r <= res_nxt;
  end

  assign out_valid       = v3_r;
  assign out_result_bits = res_r;

  // A held result must not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_bits))
    else $error("result changed under stall");
  // Full pipeline with stalled output refuses input.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && v2_r && v3_r && !out_ready |-> !in_ready)
    else $error("accepted into full pipeline");
  // A transfer in reaches stage one.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transfer lost");
endmodule

@@ hw/rtl/jtcu_decode.sv @@
// Stage 1: operand unpacking, sign/magnitude and leading zero count.
`timescale 1ns / 1ps
module jtcu_decode (
  input  logic [3:0]     op_i,
  input  logic [63:0]    bits_i,
  output jtcu_pkg::dec_t dec_o
);
  logic [31:0] lo;
  logic [63:0] mag;
  logic        neg;
  logic [7:0]  fe;
  logic [22:0] fm;
  logic [10:0] de;
  logic [51:0] dm;
  jtcu_pkg::op_t op;

  always_comb begin
    op  = jtcu_pkg::op_t'(op_i);
    lo  = bits_i[31:0];
    fe  = lo[30:23];
    fm  = lo[22:0];
    de  = bits_i[62:52];
    dm  = bits_i[51:0];
    dec_o = '0;
    dec_o.op = op;
    neg = 1'b0;
    mag = '0;
    case (op)
      jtcu_pkg::OP_I2F, jtcu_pkg::OP_I2D: begin
        neg = lo[31];
        mag = {32'd0, neg ? (32'd0 - lo) : lo};
        dec_o.is_zero = (lo == 32'd0);
      end
      jtcu_pkg::OP_L2F, jtcu_pkg::OP_L2D: begin
        neg = bits_i[63];
        mag = neg ? (64'd0 - bits_i) : bits_i;
        dec_o.is_zero = (bits_i == 64'd0);
      end
      jtcu_pkg::OP_F2I, jtcu_pkg::OP_F2L, jtcu_pkg::OP_F2D: begin
        neg = lo[31];
        mag = {(fe != 8'd0), fm, 40'd0};
        dec_o.is_nan  = (fe == 8'hFF) && (fm != 23'd0);
        dec_o.is_inf  = (fe == 8'hFF) && (fm == 23'd0);
        dec_o.is_zero = (fe == 8'd0) && (fm == 23'd0);
        // subnormal: exponent of bit 63 position is -126
        dec_o.uexp = (fe == 8'd0) ? -13'sd126 : 13'(signed'({5'd0, fe})) - 13'sd127;
        if (fe == 8'd0) mag = {1'b0, fm, 40'd0};
        // f2i/f2l subnormals are flagged as zero below
      end
      jtcu_pkg::OP_D2I, jtcu_pkg::OP_D2L, jtcu_pkg::OP_D2F: begin
        neg = bits_i[63];
        mag = {(de != 11'd0), dm, 11'd0};
        dec_o.is_nan  = (de == 11'h7FF) && (dm != 52'd0);
        dec_o.is_inf  = (de == 11'h7FF) && (dm == 52'd0);
        // d2f, d2i, d2l: subnormal doubles give signed zero / 0
        dec_o.is_zero = (de == 11'd0);
        dec_o.uexp = 13'(signed'({2'd0, de})) - 13'sd1023;
      end
      default: ;
    endcase
    // Integer ops: exponent of bit 63 is 63.
    if (op == jtcu_pkg::OP_I2F || op == jtcu_pkg::OP_I2D ||
        op == jtcu_pkg::OP_L2F || op == jtcu_pkg::OP_L2D) begin
      dec_o.uexp = 13'sd63;
    end
    // f2i/f2l on subnormal floats yield zero.
    if ((op == jtcu_pkg::OP_F2I || op == jtcu_pkg::OP_F2L) && fe == 8'd0) dec_o.is_zero = 1'b1;
    dec_o.neg = neg;
    dec_o.mag = mag;
    dec_o.lz  = jtcu_pkg::lzc64(mag);
    // Direct results.
    case (op)
      jtcu_pkg::OP_I2L: dec_o.raw = {{32{lo[31]}}, lo};
      jtcu_pkg::OP_L2I: dec_o.raw = {32'd0, lo};
      jtcu_pkg::OP_I2B: dec_o.raw = {32'd0, {24{lo[7]}}, lo[7:0]};
      jtcu_pkg::OP_I2C: dec_o.raw = {48'd0, lo[15:0]};
      jtcu_pkg::OP_I2S: dec_o.raw = {32'd0, {16{lo[15]}}, lo[15:0]};
      default:          dec_o.raw = '0;
    endcase
  end
endmodule

@@ hw/rtl/jtcu_normalize.sv @@
// Stage 2: left-justify the magnitude and adjust the exponent.
`timescale 1ns / 1ps
module jtcu_normalize (
  input  jtcu_pkg::dec_t dec_i,
  output jtcu_pkg::nrm_t nrm_o
);
  logic [5:0] sh;

  always_comb begin
    sh = dec_i.lz[5:0];
    nrm_o.op      = dec_i.op;
    nrm_o.neg     = dec_i.neg;
    nrm_o.norm    = dec_i.mag << sh;
    nrm_o.uexp    = dec_i.uexp - 13'(signed'({7'd0, sh}));
    nrm_o.is_zero = dec_i.is_zero || (dec_i.mag == 64'd0);
    nrm_o.is_nan  = dec_i.is_nan;
    nrm_o.is_inf  = dec_i.is_inf;
    nrm_o.raw     = dec_i.raw;
    // NaN payload must survive unshifted for f2d/d2f
    if (dec_i.is_nan) nrm_o.norm = dec_i.mag;
  end
endmodule

@@ hw/rtl/jtcu_pack.sv @@
// Stage 3: rounding, saturation and packing of the result.
`timescale 1ns / 1ps
module jtcu_pack (
  input  jtcu_pkg::nrm_t nrm_i,
  output logic [63:0]    result_o
);
  localparam logic [63:0] QNAN_D = 64'h7FF8_0000_0000_0000;

  logic [63:0] n, sh, mag, iv;
  logic [7:0]  amt;
  logic [6:0]  amt7;
  logic [31:0] fbits;
  logic [63:0] dbits;
  logic [63:0] r;
  logic        s, is64;
  logic signed [12:0] e;
  logic [31:0] kf;
  logic [53:0] kd;
  logic        lsb, rb, st, up;

  always_comb begin
    n = nrm_i.norm;
    s = nrm_i.neg;
    e = nrm_i.uexp;
    r = '0;
    mag = '0; iv = '0; sh = '0; amt = '0; amt7 = '0;
    fbits = '0; dbits = '0; kf = '0; kd = '0;
    lsb = 1'b0; rb = 1'b0; st = 1'b0; up = 1'b0;
    is64 = 1'b0;
    case (nrm_i.op)
      jtcu_pkg::OP_I2L, jtcu_pkg::OP_L2I, jtcu_pkg::OP_I2B,
      jtcu_pkg::OP_I2C, jtcu_pkg::OP_I2S: r = nrm_i.raw;

      // to float32 (rounding from int/long or from double)
      jtcu_pkg::OP_I2F, jtcu_pkg::OP_L2F, jtcu_pkg::OP_D2F: begin
        if (nrm_i.is_nan) begin
          r = {32'd0, s, 8'hFF, n[62:40]};
          r[22] = 1'b1;
        end else if (nrm_i.is_inf) begin
          r = {32'd0, s, 8'hFF, 23'd0};
        end else if (nrm_i.is_zero) begin
          r = {32'd0, s, 31'd0};
        end else begin
          // normal if e >= -126, else denormalize
          if (e >= -13'sd126) amt7 = 7'd0;
          else if (e < -13'sd190) amt7 = 7'd64;
          else amt7 = 7'(-13'sd126 - e);
          sh  = jtcu_pkg::shr_sticky(n, amt7);
          lsb = sh[40];
          rb  = sh[39];
          st  = |sh[38:0];
          up  = rb && (st || lsb);
          kf  = {8'd0, sh[63:40]} + {31'd0, up};
          // exponent field from kept value with carry into hidden bit
          if (e >= -13'sd126)
            fbits = 32'(unsigned'(13'(e + 13'sd126))) * 32'h0080_0000 + kf;
          else
            fbits = kf;
          if (e > 13'sd127 || fbits >= 32'h7F80_0000) fbits = 32'h7F80_0000;
          r = {32'd0, s, fbits[30:0]};
        end
      end

      // to float64
      jtcu_pkg::OP_I2D, jtcu_pkg::OP_L2D, jtcu_pkg::OP_F2D: begin
        if (nrm_i.is_nan) begin
          r = {s, 11'h7FF, n[62:11]} | QNAN_D;
        end else if (nrm_i.is_inf) begin
          r = {s, 11'h7FF, 52'd0};
        end else if (nrm_i.is_zero) begin
          r = {s, 63'd0};
        end else begin
          lsb = n[11];
          rb  = n[10];
          st  = |n[9:0];
          up  = rb && (st || lsb);
          kd  = {1'b0, n[63:11]} + {53'd0, up};
          dbits = {51'd0, 13'(e + 13'sd1022)} * 64'h0010_0000_0000_0000 + {10'd0, kd};
          r = {s, dbits[62:0]};
        end
      end

      // to int/long, truncating
      jtcu_pkg::OP_F2I, jtcu_pkg::OP_F2L, jtcu_pkg::OP_D2I, jtcu_pkg::OP_D2L: begin
        is64 = (nrm_i.op == jtcu_pkg::OP_F2L) || (nrm_i.op == jtcu_pkg::OP_D2L);
        if (nrm_i.is_nan || nrm_i.is_zero || e < 13'sd0) begin
          r = '0;
        end else if (nrm_i.is_inf || (is64 && e >= 13'sd63) || (!is64 && e >= 13'sd31)) begin
          if (is64) r = s ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
          else      r = s ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
        end else begin
          amt  = 8'(7'd63 - 7'(e));
          mag  = n >> amt[5:0];
          iv   = s ? (64'd0 - mag) : mag;
          r    = is64 ? iv : {32'd0, iv[31:0]};
        end
      end

      default: r = '0;
    endcase
    result_o = r;
  end
endmodule
